### design/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, constants and table builders for the stereo phaser.
// ----------------------------------------------------------------------------
package spa_pkg;

	localparam int MAX_STAGES_DEF   = 12;
	localparam int SINE_DEPTH_DEF   = 1024;
	localparam int TAN_DEPTH_DEF    = 1024;
	localparam int SAMPLE_W         = 24;

	localparam int FREQ_W = 27;
	localparam int TAN_W  = 31;

	localparam logic [63:0] ONE_Q30        = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [63:0] QUARTER_PI_Q30 = 64'd843314857;
	localparam logic [63:0] QUARTER_PI_Q32 = 64'd3373259426;
	localparam logic [63:0] F_MIN_Q16      = 64'd13107200;
	localparam logic [63:0] F_MAX_Q16      = 64'd131072000;

	localparam logic [15:0] FB_MAX  = 16'd62259;
	localparam logic [16:0] MIX_ONE = 17'd65536;

	localparam int CFG_W     = 23;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_PER_HZ  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL     = 3'd4;

	localparam logic [3:0]  STAGE_COUNT_RST = 4'd4;
	localparam logic [22:0] LFO_STEP_RST    = 23'd44739;
	localparam logic [20:0] ANGLE_RST       = 21'd281104;
	localparam logic [15:0] FEEDBACK_RST    = 16'd0;
	localparam logic [16:0] MIX_RST         = 17'd32768;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} src_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} dst_item_t;

	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] y1;
	} stage_state_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] a1;
	} coef_res_t;

	typedef enum logic [2:0] {
		C_IDLE, C_FREQ, C_THETA, C_NUM, C_DIV, C_FIX, C_TAN, C_DONE
	} coef_st_t;

	typedef enum logic [3:0] {
		S_IDLE, S_COEF, S_FB, S_VIN, S_MUL, S_ACC, S_MIX1, S_MIX2, S_MIX3, S_OUT
	} phs_st_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		logic signed [71:0] hi;
		logic signed [71:0] lo;
		hi = 72'sd2147483647;
		lo = -72'sd2147483648;
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

	// elaboration-time long division
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] taylor_div(input int i);
		case (i)
			0: return 64'd110;
			1: return 64'd72;
			2: return 64'd42;
			3: return 64'd20;
			default: return 64'd6;
		endcase
	endfunction

	function automatic logic [63:0] sin_quadrant(input logic [63:0] a_in);
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] d;
		a = (a_in > HALF_PI_Q30) ? HALF_PI_Q30 : a_in;
		x2 = (a * a) >> 30;
		t = ONE_Q30;
		for (int i = 0; i < 5; i++) begin
			d = udiv((x2 * t) >> 30, taylor_div(i));
			t = (d > ONE_Q30) ? 64'd0 : ONE_Q30 - d;
		end
		t = (a * t) >> 30;
		return (t > ONE_Q30) ? ONE_Q30 : t;
	endfunction

	// frequency in Q16.16 for sine table entry k
	function automatic logic [63:0] sine_freq(input int k, input int depth);
		logic [63:0] p;
		logic [63:0] quad;
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] u;
		logic [63:0] f;
		p = udiv(64'(k) << 32, 64'(depth));
		quad = (p >> 30) & 64'd3;
		r = p & (ONE_Q30 - 64'd1);
		if (quad[0]) r = ONE_Q30 - r;
		s = sin_quadrant((r * HALF_PI_Q30) >> 30);
		u = quad[1] ? ONE_Q30 - s : ONE_Q30 + s;
		f = F_MIN_Q16 + ((64'd900 * u) >> 14);
		if (f < F_MIN_Q16) f = F_MIN_Q16;
		if (f > F_MAX_Q16) f = F_MAX_Q16;
		return f;
	endfunction

	// tangent magnitude in Q1.30 for tangent table entry k
	function automatic logic [63:0] tan_mag(input int k, input int depth);
		logic [63:0] m;
		logic [63:0] sn;
		logic [63:0] cs;
		logic [63:0] tv;
		m = udiv(64'(depth - k) * QUARTER_PI_Q30, 64'(depth));
		sn = sin_quadrant(m);
		cs = sin_quadrant(HALF_PI_Q30 - m);
		if (cs == 64'd0) cs = 64'd1;
		tv = udiv(sn << 30, cs);
		return (tv > ONE_Q30) ? ONE_Q30 : tv;
	endfunction

endpackage

### design/stereo_phaser_allpass_lfo_unit.sv
// ----------------------------------------------------------------------------
// stereo_phaser_allpass_lfo_unit
// Stereo phaser: LFO-swept allpass cascade per channel with feedback and mix.
// ----------------------------------------------------------------------------
// The block takes one item at a time: once the coefficient is ready, one state
// memory port walks both channels stage by stage, mixing each channel after
// its last stage. No new item is taken until the result leaves the output step,
// and a waiting result holds the block in its output step. Reset: config to
// defaults, LFO phase, feedback and stage state read as zero.
module stereo_phaser_allpass_lfo_unit #(
	parameter int MAX_STAGES       = spa_pkg::MAX_STAGES_DEF,
	parameter int SINE_TABLE_DEPTH = spa_pkg::SINE_DEPTH_DEF,
	parameter int TAN_TABLE_DEPTH  = spa_pkg::TAN_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  spa_pkg::src_item_t             src_item,
	output logic                           dst_valid,
	input  logic                           dst_stall,
	output spa_pkg::dst_item_t             dst_item,
	input  logic                           cfg_wen,
	input  logic [spa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spa_pkg::CFG_W-1:0]      cfg_data
);

	localparam int SW    = spa_pkg::SAMPLE_W;
	localparam int FBITS = SW - 2;
	localparam int LSH   = (FBITS <= 24) ? 24 - FBITS : 0;
	localparam int RSH   = (FBITS > 24) ? FBITS - 24 : 0;
	localparam int MSH   = 40 - FBITS;
	localparam int DEPTH = 2 * MAX_STAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int STW   = $clog2(MAX_STAGES);

	localparam logic signed [71:0] RND_FB  = 72'sd32768;
	localparam logic signed [71:0] RND_STG = 72'sd1 <<< 29;
	localparam logic signed [71:0] RND_MIX = 72'sd1 <<< (MSH - 1);
	localparam logic signed [71:0] OMAX    = (72'sd1 <<< (SW - 1)) - 72'sd1;
	localparam logic signed [71:0] OMIN    = -(72'sd1 <<< (SW - 1));

	logic [3:0]  stage_count_q;
	logic [22:0] lfo_step_q;
	logic [20:0] angle_q;
	logic [15:0] fbg_q;
	logic [16:0] mix_q;

	spa_pkg::phs_st_t state_q, state_d;

	logic                  src_acc;
	logic                  coef_start;
	spa_pkg::coef_res_t    coef_res;
	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	spa_pkg::stage_state_t rd_data, wr_data;

	logic signed [SW-1:0] x_q [2];
	logic signed [31:0]   fb_q [2];
	logic signed [SW-1:0] res_q [2];
	logic                 ch_q;
	logic [STW-1:0]       stage_q;
	logic signed [31:0]   v_q;
	logic signed [48:0]   prod_fb_s1;
	logic signed [64:0]   prod_s1;
	logic signed [31:0]   x1_s1;
	logic signed [51:0]   ma_s1;
	logic signed [49:0]   mb_s1;
	spa_pkg::dst_item_t   dst_item_q;
	logic                 dst_valid_q;

	logic [5:0]           n_eff;
	logic [15:0]          fbg_eff;
	logic [16:0]          mix_eff;
	logic [16:0]          mix_inv;
	logic signed [33:0]   x24;
	logic signed [31:0]   v_in;
	logic signed [31:0]   y_acc;
	logic signed [71:0]   mix_sum;
	logic signed [SW-1:0] mix_out;
	logic                 last_stage;
	logic [AW-1:0]        ch_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= spa_pkg::STAGE_COUNT_RST;
			lfo_step_q    <= spa_pkg::LFO_STEP_RST;
			angle_q       <= spa_pkg::ANGLE_RST;
			fbg_q         <= spa_pkg::FEEDBACK_RST;
			mix_q         <= spa_pkg::MIX_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				spa_pkg::CFG_STAGE_COUNT:   stage_count_q <= cfg_data[3:0];
				spa_pkg::CFG_LFO_STEP:      lfo_step_q    <= cfg_data[22:0];
				spa_pkg::CFG_ANGLE_PER_HZ:  angle_q       <= cfg_data[20:0];
				spa_pkg::CFG_FEEDBACK_GAIN: fbg_q         <= cfg_data[15:0];
				spa_pkg::CFG_MIX_LEVEL:     mix_q         <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (stage_count_q < 4'd4) begin
			n_eff = 6'd4;
		end else if (6'(stage_count_q) > 6'(MAX_STAGES)) begin
			n_eff = 6'(MAX_STAGES);
		end else begin
			n_eff = 6'(stage_count_q);
		end
		fbg_eff = (fbg_q > spa_pkg::FB_MAX) ? spa_pkg::FB_MAX : fbg_q;
		mix_eff = (mix_q > spa_pkg::MIX_ONE) ? spa_pkg::MIX_ONE : mix_q;
		mix_inv = spa_pkg::MIX_ONE - mix_eff;
		x24     = (34'(x_q[ch_q]) <<< LSH) >>> RSH;
		v_in    = spa_pkg::sat32(72'(x24) + ((72'(prod_fb_s1) + RND_FB) >>> 16));
		y_acc   = spa_pkg::sat32(((72'(prod_s1) + RND_STG) >>> 30) + 72'(x1_s1));
		mix_sum = (72'(ma_s1) + 72'(mb_s1) + RND_MIX) >>> MSH;
		if (mix_sum > OMAX) begin
			mix_out = OMAX[SW-1:0];
		end else if (mix_sum < OMIN) begin
			mix_out = OMIN[SW-1:0];
		end else begin
			mix_out = mix_sum[SW-1:0];
		end
		last_stage = ((6'(stage_q) + 6'd1) >= n_eff);
		ch_base    = ch_q ? AW'(MAX_STAGES) : '0;
	end

	assign src_acc = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		src_stall  = (state_q != spa_pkg::S_IDLE);
		coef_start = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = ch_base;
		wr_en      = 1'b0;
		case (state_q)
			spa_pkg::S_IDLE: begin
				if (src_valid) begin
					coef_start = 1'b1;
					state_d    = spa_pkg::S_COEF;
				end
			end
			spa_pkg::S_COEF: begin
				if (coef_res.done) state_d = spa_pkg::S_FB;
			end
			spa_pkg::S_FB: begin
				rd_en   = 1'b1;
				state_d = spa_pkg::S_VIN;
			end
			spa_pkg::S_VIN: state_d = spa_pkg::S_MUL;
			spa_pkg::S_MUL: begin
				rd_en   = !last_stage;
				rd_addr = ch_base + AW'(stage_q) + AW'(1);
				state_d = spa_pkg::S_ACC;
			end
			spa_pkg::S_ACC: begin
				wr_en   = 1'b1;
				state_d = last_stage ? spa_pkg::S_MIX1 : spa_pkg::S_MUL;
			end
			spa_pkg::S_MIX1: state_d = spa_pkg::S_MIX2;
			spa_pkg::S_MIX2: state_d = spa_pkg::S_MIX3;
			spa_pkg::S_MIX3: state_d = ch_q ? spa_pkg::S_OUT : spa_pkg::S_FB;
			spa_pkg::S_OUT: begin
				if (!dst_valid_q || !dst_stall) state_d = spa_pkg::S_IDLE;
			end
			default: state_d = spa_pkg::S_IDLE;
		endcase
	end

	assign wr_addr = ch_base + AW'(stage_q);
	assign wr_data = '{x1: v_q, y1: y_acc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q[0]     <= '0;
			fb_q[1]     <= '0;
			dst_valid_q <= 1'b0;
		end else begin
			if (state_q == spa_pkg::S_ACC && last_stage) begin
				fb_q[ch_q] <= y_acc;
			end
			if (state_q == spa_pkg::S_OUT && (!dst_valid_q || !dst_stall)) begin
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spa_pkg::S_IDLE: begin
				if (src_acc) begin
					x_q[0] <= src_item.left_in;
					x_q[1] <= src_item.right_in;
					ch_q   <= 1'b0;
				end
			end
			spa_pkg::S_FB: begin
				prod_fb_s1 <= $signed({1'b0, fbg_eff}) * fb_q[ch_q];
				stage_q    <= '0;
			end
			spa_pkg::S_VIN: v_q <= v_in;
			spa_pkg::S_MUL: begin
				prod_s1 <= coef_res.a1 * (33'(v_q) - 33'(rd_data.y1));
				x1_s1   <= rd_data.x1;
			end
			spa_pkg::S_ACC: begin
				v_q     <= y_acc;
				stage_q <= stage_q + 1'b1;
			end
			spa_pkg::S_MIX1: ma_s1 <= x24 * $signed({1'b0, mix_inv});
			spa_pkg::S_MIX2: mb_s1 <= v_q * $signed({1'b0, mix_eff});
			spa_pkg::S_MIX3: begin
				res_q[ch_q] <= mix_out;
				ch_q        <= 1'b1;
			end
			spa_pkg::S_OUT: begin
				if (!dst_valid_q || !dst_stall) begin
					dst_item_q.left_out  <= res_q[0];
					dst_item_q.right_out <= res_q[1];
				end
			end
			default: ;
		endcase
	end

	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

	spa_coef_unit #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.TAN_TABLE_DEPTH  (TAN_TABLE_DEPTH)
	) u_coef (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (coef_start),
		.lfo_step     (lfo_step_q),
		.angle_per_hz (angle_q),
		.res          (coef_res)
	);

	spa_state_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	a_coef_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		coef_res.done |-> state_q == spa_pkg::S_COEF)
		else $error("coefficient ready outside wait");

	a_stage_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spa_pkg::S_ACC |-> 6'(stage_q) < n_eff)
		else $error("stage index beyond stage count");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		src_acc |=> !$rose(dst_valid))
		else $error("result right after item");

endmodule

### design/spa_state_mem.sv
// ----------------------------------------------------------------------------
// spa_state_mem
// Allpass stage state store: one entry per channel and stage, registered read.
// ----------------------------------------------------------------------------
module spa_state_mem #(
	parameter int DEPTH = 2 * spa_pkg::MAX_STAGES_DEF,
	parameter int AW    = $clog2(2 * spa_pkg::MAX_STAGES_DEF)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output spa_pkg::stage_state_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  spa_pkg::stage_state_t wr_data
);

	spa_pkg::stage_state_t mem [DEPTH];
	spa_pkg::stage_state_t data_q;
	logic [DEPTH-1:0]      vld_q;
	logic                  hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

### design/spa_coef_unit.sv
// ----------------------------------------------------------------------------
// spa_coef_unit
// LFO phase, sine and tangent tables and the reciprocal index estimate for a1.
// ----------------------------------------------------------------------------
module spa_coef_unit #(
	parameter int SINE_TABLE_DEPTH = spa_pkg::SINE_DEPTH_DEF,
	parameter int TAN_TABLE_DEPTH  = spa_pkg::TAN_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [22:0]        lfo_step,
	input  logic [20:0]        angle_per_hz,
	output spa_pkg::coef_res_t res
);

	localparam int SIW = $clog2(SINE_TABLE_DEPTH);
	localparam int TIW = $clog2(TAN_TABLE_DEPTH);
	localparam int PW  = 32 + SIW + 1;
	localparam int NW  = 32 + TIW + 1;
	localparam int NW1 = NW + 1;
	localparam int QW  = TIW + 1;
	localparam int SH  = NW + 1;
	localparam int RW  = SH - 31;
	localparam int EPW = NW + RW;
	localparam logic [63:0]   RECIP64  = spa_pkg::udiv(64'd1 << SH, spa_pkg::QUARTER_PI_Q32);
	localparam logic [RW-1:0] RECIP    = RECIP64[RW-1:0];
	localparam logic [31:0]   QPI      = 32'(spa_pkg::QUARTER_PI_Q32);
	localparam logic [QW-1:0] TIDX_MAX = QW'(TAN_TABLE_DEPTH - 1);

	typedef logic [spa_pkg::FREQ_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];
	typedef logic [spa_pkg::TAN_W-1:0]  tan_rom_t  [TAN_TABLE_DEPTH];

	function automatic sine_rom_t build_sine();
		sine_rom_t t;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			t[k] = spa_pkg::FREQ_W'(spa_pkg::sine_freq(k, SINE_TABLE_DEPTH));
		end
		return t;
	endfunction

	function automatic tan_rom_t build_tan();
		tan_rom_t t;
		for (int k = 0; k < TAN_TABLE_DEPTH; k++) begin
			t[k] = spa_pkg::TAN_W'(spa_pkg::tan_mag(k, TAN_TABLE_DEPTH));
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();
	localparam tan_rom_t  TAN_ROM  = build_tan();

	spa_pkg::coef_st_t state_q, state_d;

	logic [31:0]                 phase_q;
	logic [SIW-1:0]              sidx_q;
	logic [spa_pkg::FREQ_W-1:0]  f_q;
	logic [31:0]                 theta_q;
	logic [NW-1:0]               num_q;
	logic [QW-1:0]               kest_q;
	logic [QW-1:0]               quot_q;
	logic [spa_pkg::TAN_W-1:0]   tv_q;

	logic [PW-1:0]  sprod;
	logic [47:0]    tprod;
	logic [EPW-1:0] est_prod;
	logic [NW1-1:0] chk;
	logic [TIW-1:0] tidx;

	assign sprod    = PW'(phase_q) * PW'(SINE_TABLE_DEPTH);
	assign tprod    = 48'(f_q) * 48'(angle_per_hz);
	assign est_prod = EPW'(num_q) * EPW'(RECIP);
	assign chk      = NW1'(kest_q) * NW1'(QPI) + NW1'(QPI);
	assign tidx     = (quot_q > TIDX_MAX) ? TIDX_MAX[TIW-1:0] : quot_q[TIW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spa_pkg::C_IDLE;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == spa_pkg::C_IDLE && start) begin
				phase_q <= phase_q + 32'(lfo_step);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			spa_pkg::C_IDLE:  if (start) state_d = spa_pkg::C_FREQ;
			spa_pkg::C_FREQ:  state_d = spa_pkg::C_THETA;
			spa_pkg::C_THETA: state_d = spa_pkg::C_NUM;
			spa_pkg::C_NUM:   state_d = spa_pkg::C_DIV;
			spa_pkg::C_DIV:   state_d = spa_pkg::C_FIX;
			spa_pkg::C_FIX:   state_d = spa_pkg::C_TAN;
			spa_pkg::C_TAN:   state_d = spa_pkg::C_DONE;
			spa_pkg::C_DONE:  state_d = spa_pkg::C_IDLE;
			default:          state_d = spa_pkg::C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spa_pkg::C_IDLE: begin
				if (start) sidx_q <= sprod[32 +: SIW];
			end
			spa_pkg::C_FREQ: f_q <= SINE_ROM[sidx_q];
			spa_pkg::C_THETA: theta_q <= tprod[47:16];
			spa_pkg::C_NUM: num_q <= NW'(theta_q) * NW'(TAN_TABLE_DEPTH);
			// estimate is exact or one short
			spa_pkg::C_DIV: kest_q <= est_prod[SH +: QW];
			spa_pkg::C_FIX: begin
				quot_q <= (chk <= {1'b0, num_q}) ? kest_q + QW'(1) : kest_q;
			end
			spa_pkg::C_TAN: tv_q <= TAN_ROM[tidx];
			default: ;
		endcase
	end

	assign res.done = (state_q == spa_pkg::C_DONE);
	assign res.a1   = -$signed(32'(tv_q));

endmodule

### dv/tb_stereo_phaser_allpass_lfo_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_phaser_allpass_lfo_unit
// Self-checking bench for the stereo phaser. A bit-true model of the LFO,
// the tangent coefficient, the allpass cascades and the mix predicts every
// output item. Stimulus runs directed extremes, a register sweep, a long
// receiver hold-off and a random run, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_stereo_phaser_allpass_lfo_unit;

	localparam int NSTG      = 12;
	localparam int WDOG_MAX  = 5000;
	localparam int SETTLE    = 120;

	logic               clk;
	logic               arst_n;
	logic               src_valid;
	logic               src_stall;
	spa_pkg::src_item_t src_item;
	logic               dst_valid;
	logic               dst_stall;
	spa_pkg::dst_item_t dst_item;
	logic               cfg_wen;
	logic [spa_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [spa_pkg::CFG_W-1:0]     cfg_data;

	stereo_phaser_allpass_lfo_unit dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst_item(dst_item),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// model registers and state
	logic [3:0]  m_stages;
	logic [22:0] m_step;
	logic [20:0] m_angle;
	logic [15:0] m_fb;
	logic [16:0] m_mix;
	logic [31:0] m_phase;
	logic signed [31:0] m_x1 [2][NSTG];
	logic signed [31:0] m_y1 [2][NSTG];
	logic signed [31:0] m_fbk [2];

	spa_pkg::dst_item_t expected_q[$];
	int        errors;
	int        quiet;
	int        hold_req;
	int        idle_cnt;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned quad_sine(longint unsigned a_in);
		longint unsigned a, x2, t, d;
		longint unsigned dv [5];
		dv = '{110, 72, 42, 20, 6};
		a = (a_in > spa_pkg::HALF_PI_Q30) ? spa_pkg::HALF_PI_Q30 : a_in;
		x2 = (a * a) >> 30;
		t = spa_pkg::ONE_Q30;
		for (int i = 0; i < 5; i++) begin
			d = ((x2 * t) >> 30) / dv[i];
			t = (d > spa_pkg::ONE_Q30) ? 64'd0 : spa_pkg::ONE_Q30 - d;
		end
		t = (a * t) >> 30;
		return (t > spa_pkg::ONE_Q30) ? spa_pkg::ONE_Q30 : t;
	endfunction

	function automatic longint signed lfo_sine(logic [31:0] ph);
		longint unsigned k, p, quad, r;
		longint signed s;
		k = ph >> 22;
		p = k << 22;
		quad = (p >> 30) & 3;
		r = p & (spa_pkg::ONE_Q30 - 1);
		if (quad[0]) r = spa_pkg::ONE_Q30 - r;
		s = longint'(quad_sine((r * spa_pkg::HALF_PI_Q30) >> 30));
		return quad[1] ? -s : s;
	endfunction

	function automatic longint signed sweep_coef(longint unsigned fq);
		longint unsigned theta, k, m, sn, cs, tv;
		theta = (fq * longint'(m_angle)) >> 16;
		k = (theta * 1024) / spa_pkg::QUARTER_PI_Q32;
		if (k > 1023) k = 1023;
		m = ((1024 - k) * spa_pkg::QUARTER_PI_Q30) / 1024;
		sn = quad_sine(m);
		cs = quad_sine(spa_pkg::HALF_PI_Q30 - m);
		if (cs == 0) cs = 1;
		tv = (sn << 30) / cs;
		if (tv > spa_pkg::ONE_Q30) tv = spa_pkg::ONE_Q30;
		return -longint'(tv);
	endfunction

	function automatic longint signed clip32(longint signed v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic spa_pkg::dst_item_t phaser_output(spa_pkg::src_item_t it);
		int n;
		longint unsigned fbg, mix, u, f;
		longint signed a1, x, v, y, sum;
		logic signed [79:0] prod;
		logic signed [spa_pkg::SAMPLE_W-1:0] res [2];
		spa_pkg::dst_item_t o;
		n = m_stages < 4 ? 4 : (m_stages > NSTG ? NSTG : m_stages);
		fbg = m_fb > spa_pkg::FB_MAX ? spa_pkg::FB_MAX : m_fb;
		mix = m_mix > spa_pkg::MIX_ONE ? spa_pkg::MIX_ONE : m_mix;
		u = longint'(lfo_sine(m_phase) + longint'(spa_pkg::ONE_Q30));
		m_phase = m_phase + 32'(m_step);
		f = spa_pkg::F_MIN_Q16 + ((900 * u) >> 14);
		if (f < spa_pkg::F_MIN_Q16) f = spa_pkg::F_MIN_Q16;
		if (f > spa_pkg::F_MAX_Q16) f = spa_pkg::F_MAX_Q16;
		a1 = sweep_coef(f);
		for (int c = 0; c < 2; c++) begin
			x = (c == 0) ? longint'(it.left_in) : longint'(it.right_in);
			v = x * 4 + ((longint'(fbg) * longint'(m_fbk[c]) + 32768) >>> 16);
			v = clip32(v);
			for (int i = 0; i < n; i++) begin
				prod = 80'(a1) * 80'(v - longint'(m_y1[c][i])) + (80'sd1 <<< 29);
				y = clip32(longint'(prod >>> 30) + longint'(m_x1[c][i]));
				m_x1[c][i] = 32'(v);
				m_y1[c][i] = 32'(y);
				v = y;
			end
			m_fbk[c] = 32'(v);
			sum = x * 4 * longint'(spa_pkg::MIX_ONE - mix) + v * longint'(mix);
			sum = (sum + (64'sd1 <<< 17)) >>> 18;
			if (sum > 8388607) sum = 8388607;
			if (sum < -8388608) sum = -8388608;
			res[c] = spa_pkg::SAMPLE_W'(sum);
		end
		o.left_out  = res[0];
		o.right_out = res[1];
		return o;
	endfunction

	task automatic send_item(spa_pkg::src_item_t it);
		while (!quiet && $urandom_range(99) < 16) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do @(posedge clk); while (src_stall);
		expected_q.push_back(phaser_output(it));
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [spa_pkg::CFG_IDX_W-1:0] idx,
		logic [spa_pkg::CFG_W-1:0] val);
		drain();
		cfg_wen  <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			spa_pkg::CFG_STAGE_COUNT:   m_stages = val[3:0];
			spa_pkg::CFG_LFO_STEP:      m_step   = val[22:0];
			spa_pkg::CFG_ANGLE_PER_HZ:  m_angle  = val[20:0];
			spa_pkg::CFG_FEEDBACK_GAIN: m_fb     = val[15:0];
			spa_pkg::CFG_MIX_LEVEL:     m_mix    = val[16:0];
			default: ;
		endcase
	endtask

	task automatic set_all(int st, int stp, int ang, int fb, int mx);
		write_reg(spa_pkg::CFG_STAGE_COUNT, spa_pkg::CFG_W'(st));
		write_reg(spa_pkg::CFG_LFO_STEP, spa_pkg::CFG_W'(stp));
		write_reg(spa_pkg::CFG_ANGLE_PER_HZ, spa_pkg::CFG_W'(ang));
		write_reg(spa_pkg::CFG_FEEDBACK_GAIN, spa_pkg::CFG_W'(fb));
		write_reg(spa_pkg::CFG_MIX_LEVEL, spa_pkg::CFG_W'(mx));
	endtask

	function automatic spa_pkg::src_item_t rand_item();
		spa_pkg::src_item_t it;
		case ($urandom_range(9))
			0: begin
				it.left_in  = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
				it.right_in = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
			end
			1: begin
				it.left_in  = 24'($signed($urandom_range(2047)) - 1024);
				it.right_in = 24'($signed($urandom_range(2047)) - 1024);
			end
			default: begin
				it.left_in  = 24'($urandom);
				it.right_in = 24'($urandom);
			end
		endcase
		return it;
	endfunction

	function automatic spa_pkg::src_item_t pair(int l, int r);
		spa_pkg::src_item_t it;
		it.left_in  = 24'(l);
		it.right_in = 24'(r);
		return it;
	endfunction

	task automatic test_directed_extremes();
		send_item(pair(0, 0));
		send_item(pair(8388607, -8388608));
		send_item(pair(-8388608, 8388607));
		send_item(pair(8388607, 8388607));
		send_item(pair(-8388608, -8388608));
		send_item(pair(1, -1));
		send_item(pair(4194304, -4194304));
		send_item(pair(0, 0));
	endtask

	task automatic test_register_sweep();
		// full wet, deepest cascade, heaviest feedback, a fast LFO
		set_all(12, 5368709, 1686629, 62259, 65536);
		repeat (6) send_item(pair(8388607, -8388608));
		repeat (4) send_item(rand_item());
		// out-of-range codes, clamped by the block
		set_all(15, 2237, 2097151, 65535, 131071);
		repeat (5) send_item(rand_item());
		set_all(0, 8388607, 70276, 0, 0);
		repeat (5) send_item(rand_item());
		set_all(4, 44739, 281104, 0, 32768);
	endtask

	task automatic test_receiver_hold();
		quiet = 1;
		hold_req = 1;
		repeat (12) send_item(rand_item());
		quiet = 0;
		drain();
	endtask

	task automatic test_random_run();
		for (int blk = 0; blk < 6; blk++) begin
			if (blk == 2) quiet = 1;
			set_all($urandom_range(15), $urandom_range(5368709, 2237),
				$urandom_range(1686629, 70276),
				$urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(62259),
				$urandom_range(4) == 0 ? $urandom_range(131071) : $urandom_range(65536));
			repeat (250) send_item(rand_item());
			quiet = 0;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		spa_pkg::dst_item_t e;
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected item: left_out %0d right_out %0d",
					dst_item.left_out, dst_item.right_out);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (dst_item.left_out !== e.left_out) begin
					$error("left_out: expected %0d, got %0d", e.left_out, dst_item.left_out);
					errors++;
				end
				if (dst_item.right_out !== e.right_out) begin
					$error("right_out: expected %0d, got %0d", e.right_out, dst_item.right_out);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = 400;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dst_stall <= 1'b1;
			end else
				dst_stall <= (!quiet && $urandom_range(99) < 16);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
			idle_cnt <= 0;
		else if (idle_cnt >= WDOG_MAX) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			idle_cnt <= idle_cnt + 1;
	end

	initial begin
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_item  = '0;
		dst_stall = 1'b0;
		cfg_wen   = 1'b0;
		cfg_idx   = '0;
		cfg_data  = '0;
		errors    = 0;
		quiet     = 0;
		hold_req  = 0;
		idle_cnt  = 0;
		m_stages  = spa_pkg::STAGE_COUNT_RST;
		m_step    = spa_pkg::LFO_STEP_RST;
		m_angle   = spa_pkg::ANGLE_RST;
		m_fb      = spa_pkg::FEEDBACK_RST;
		m_mix     = spa_pkg::MIX_RST;
		m_phase   = '0;
		m_fbk     = '{0, 0};
		for (int c = 0; c < 2; c++)
			for (int i = 0; i < NSTG; i++) begin
				m_x1[c][i] = '0;
				m_y1[c][i] = '0;
			end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_register_sweep();
		test_receiver_hold();
		test_random_run();

		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
design/spa_pkg.sv
design/spa_state_mem.sv
design/spa_coef_unit.sv
design/stereo_phaser_allpass_lfo_unit.sv
dv/tb_stereo_phaser_allpass_lfo_unit.sv
